// ----- hw/rtl/adcseq_pkg.sv -----
// Shared types, constants and register codes for the converter sample sequencer.
`timescale 1ns / 1ps

package adcseq_pkg;

  // Default for the converter resolution parameter of the top level.
  localparam int unsigned ADC_BITS_DEF = 12;

  // Field and register widths.
  localparam int unsigned SAMPLE_IN_W = 12;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned TIMEOUT_W   = 8;
  localparam int unsigned OFFSET_W    = 12;
  localparam int unsigned CUR_W       = 11;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register values after reset.
  localparam logic [PERIOD_W-1:0]  PERIOD_RST  = PERIOD_W'(100);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(10);
  localparam logic [OFFSET_W-1:0]  OFFSET_RST  = '0;

  // Wait counter saturates at its all-ones value.
  localparam logic [TIMEOUT_W-1:0] WAIT_MAX = '1;

  // Scaling of a converter reading to mA: diff * 1636 / 573 / 10. The two truncating
  // divisions equal one division by 5730, which is done as a multiplication by a
  // rounded-up reciprocal. With a 25-bit shift the error stays below one step of the
  // divisor for every 12-bit difference, so the quotient is exact.
  localparam int unsigned MA_SCALE_X10 = 1636;
  localparam int unsigned ADC_REF      = 573;
  localparam int unsigned TENTHS       = 10;
  localparam int unsigned MA_DIV       = ADC_REF * TENTHS;
  localparam int unsigned MA_SHIFT     = 25;
  localparam int unsigned MA_RECIP_W   = 24;
  localparam logic [MA_RECIP_W-1:0] MA_RECIP =
      MA_RECIP_W'(((64'(MA_SCALE_X10) << MA_SHIFT) + 64'(MA_DIV) - 64'd1) / 64'(MA_DIV));
  localparam int unsigned MA_PROD_W    = OFFSET_W + MA_RECIP_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_PERIOD = 2'd0,
    CFG_TIMEOUT       = 2'd1,
    CFG_ZERO_OFFSET   = 2'd2
  } cfg_idx_e;

  // Kinds of input item; the fourth code changes nothing.
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_DONE  = 2'd1,
    MODE_ERROR = 2'd2
  } mode_e;

  // Sequencer phase, one-hot.
  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_WAIT = 2'b10
  } phase_e;

  // Configuration seen by the sequencer.
  typedef struct packed {
    logic [PERIOD_W-1:0]  sample_period_ticks;
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [OFFSET_W-1:0]  zero_offset;
  } cfg_t;

  // One input item as held in the input register.
  typedef struct packed {
    logic [1:0]             mode;
    logic [SAMPLE_IN_W-1:0] sample_in;
    logic                   busy_elsewhere;
    logic                   owner_lost;
    logic                   start_ok;
  } item_t;

  // One result item as held in the result register.
  typedef struct packed {
    logic             claim_adc;
    logic             start_conversion;
    logic             stop_conversion;
    logic             release_adc;
    logic             current_valid;
    logic [CUR_W-1:0] current_ma;
    logic             waiting;
  } result_t;

endpackage

// ----- hw/rtl/adcseq_cfg_regs.sv -----
// Configuration register bank of the converter sample sequencer.
`timescale 1ns / 1ps

module adcseq_cfg_regs import adcseq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic [PERIOD_W-1:0]  period_q, period_d;
  logic [TIMEOUT_W-1:0] timeout_q, timeout_d;
  logic [OFFSET_W-1:0]  offset_q, offset_d;

  // Writes are always taken; an index beyond the list is dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    period_d  = period_q;
    timeout_d = timeout_q;
    offset_d  = offset_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SAMPLE_PERIOD: period_d  = cfg_data_i[PERIOD_W-1:0];
        CFG_TIMEOUT:       timeout_d = cfg_data_i[TIMEOUT_W-1:0];
        CFG_ZERO_OFFSET:   offset_d  = cfg_data_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= PERIOD_RST;
      timeout_q <= TIMEOUT_RST;
      offset_q  <= OFFSET_RST;
    end else begin
      period_q  <= period_d;
      timeout_q <= timeout_d;
      offset_q  <= offset_d;
    end
  end

  assign cfg_o.sample_period_ticks = period_q;
  assign cfg_o.timeout_ticks       = timeout_q;
  assign cfg_o.zero_offset         = offset_q;

endmodule

// ----- hw/rtl/adcseq_ma_conv.sv -----
// Conversion of a latched converter reading to a current in milliamperes.
`timescale 1ns / 1ps

module adcseq_ma_conv import adcseq_pkg::*; #(
  parameter int unsigned SampleW = SAMPLE_IN_W
) (
  input  logic [SampleW-1:0]  sample_i,
  input  logic [OFFSET_W-1:0] offset_i,
  output logic [CUR_W-1:0]    ma_o
);

  logic [OFFSET_W-1:0]  sample_ext;
  logic [OFFSET_W-1:0]  diff;
  logic [MA_PROD_W-1:0] prod;

  assign sample_ext = OFFSET_W'(sample_i);
  assign diff       = sample_ext - offset_i;
  assign prod       = MA_PROD_W'(diff) * MA_PROD_W'(MA_RECIP);

  // Readings at or below the offset mean no current.
  assign ma_o = (sample_ext <= offset_i) ? '0 : prod[MA_SHIFT +: CUR_W];

endmodule

// ----- hw/rtl/adcseq_ctrl.sv -----
// Input register, sequencer state and result register of the converter sample sequencer.
`timescale 1ns / 1ps

module adcseq_ctrl import adcseq_pkg::*; #(
  parameter int unsigned AdcBits = ADC_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  item_t   item_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  localparam int unsigned SampleW = (AdcBits < SAMPLE_IN_W) ? AdcBits : SAMPLE_IN_W;

  logic    in_vld_q, in_vld_d;
  item_t   in_q;
  logic    out_vld_q, out_vld_d;
  result_t res_q, res_d;
  logic    adv;

  phase_e               phase_q, phase_d;
  logic [PERIOD_W-1:0]  sample_count_q, sample_count_d;
  logic [TIMEOUT_W-1:0] wait_count_q, wait_count_d, wait_inc;
  logic                 ready_flag_q, ready_flag_d;
  logic                 error_flag_q, error_flag_d;
  logic [SampleW-1:0]   latched_q, latched_d;
  logic [CUR_W-1:0]     last_current_q, last_current_d;
  logic [CUR_W-1:0]     conv_ma;

  // The held item moves on when the result register is empty or being emptied.
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  adcseq_ma_conv #(
    .SampleW (SampleW)
  ) u_ma_conv (
    .sample_i (latched_q),
    .offset_i (cfg_i.zero_offset),
    .ma_o     (conv_ma)
  );

  assign wait_inc = (wait_count_q < WAIT_MAX) ? wait_count_q + TIMEOUT_W'(1) : wait_count_q;

  always_comb begin
    phase_d        = phase_q;
    sample_count_d = sample_count_q;
    wait_count_d   = wait_count_q;
    ready_flag_d   = ready_flag_q;
    error_flag_d   = error_flag_q;
    latched_d      = latched_q;
    last_current_d = last_current_q;
    res_d          = '0;

    unique case (in_q.mode)
      MODE_DONE: begin
        latched_d    = in_q.sample_in[SampleW-1:0];
        ready_flag_d = 1'b1;
      end
      MODE_ERROR: begin
        error_flag_d = 1'b1;
      end
      MODE_TICK: begin
        if (phase_q == PH_IDLE) begin
          if (sample_count_q < cfg_i.sample_period_ticks) begin
            sample_count_d = sample_count_q + PERIOD_W'(1);
          end else begin
            sample_count_d = '0;
            if (!in_q.busy_elsewhere && in_q.start_ok) begin
              ready_flag_d           = 1'b0;
              error_flag_d           = 1'b0;
              wait_count_d           = '0;
              res_d.claim_adc        = 1'b1;
              res_d.start_conversion = 1'b1;
              phase_d                = PH_WAIT;
            end
          end
        end else begin
          priority if (in_q.owner_lost) begin
            ready_flag_d = 1'b0;
            error_flag_d = 1'b0;
            phase_d      = PH_IDLE;
          end else if (ready_flag_q) begin
            ready_flag_d          = 1'b0;
            res_d.stop_conversion = 1'b1;
            res_d.release_adc     = 1'b1;
            res_d.current_valid   = 1'b1;
            last_current_d        = conv_ma;
            phase_d               = PH_IDLE;
          end else if (error_flag_q) begin
            error_flag_d          = 1'b0;
            res_d.stop_conversion = 1'b1;
            res_d.release_adc     = 1'b1;
            phase_d               = PH_IDLE;
          end else begin
            wait_count_d = wait_inc;
            if (wait_inc >= cfg_i.timeout_ticks) begin
              res_d.stop_conversion = 1'b1;
              res_d.release_adc     = 1'b1;
              phase_d               = PH_IDLE;
            end
          end
        end
      end
      default: ;
    endcase

    res_d.current_ma = last_current_d;
    res_d.waiting    = (phase_d == PH_WAIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
      phase_q        <= PH_IDLE;
      sample_count_q <= PERIOD_RST;
      wait_count_q   <= '0;
      ready_flag_q   <= 1'b0;
      error_flag_q   <= 1'b0;
      latched_q      <= '0;
      last_current_q <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        phase_q        <= phase_d;
        sample_count_q <= sample_count_d;
        wait_count_q   <= wait_count_d;
        ready_flag_q   <= ready_flag_d;
        error_flag_q   <= error_flag_d;
        latched_q      <= latched_d;
        last_current_q <= last_current_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= item_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = res_q;

  // A stalled result freezes the sequencer state.
  a_stall_holds_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |=> $stable(phase_q))
    else $error("phase moved while the result register was stalled");

  // The reported phase is the phase that the item left behind.
  a_waiting_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> res_q.waiting == (phase_q == PH_WAIT))
    else $error("reported phase differs from the stored phase");

  // A new measurement only comes with the converter being stopped and released.
  a_valid_with_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.current_valid |-> res_q.stop_conversion && res_q.release_adc
      && !res_q.waiting)
    else $error("measurement reported without stop and release");

  // A claim always starts a conversion and enters the waiting phase.
  a_claim_enters_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.claim_adc |-> res_q.start_conversion && res_q.waiting
      && !res_q.stop_conversion)
    else $error("claim without start or without entering the waiting phase");

endmodule

// ----- hw/rtl/adc_sample_sequencer_timeout.sv -----
// Top level of the periodic converter sampler with timeout.
`timescale 1ns / 1ps

// Periodic sampler for a converter shared with other users. Each input transfer is a
// tick, a conversion-complete event with a 12-bit sample, or a conversion-error event,
// and each one yields exactly one result transfer with the claim, start, stop and
// release pulses, the last measured current in mA and the phase after the item. In the
// idle phase a tick counter runs up to the sample period and then the block claims the
// converter and starts a conversion, unless another user holds it busy or the start
// fails. In the waiting phase each tick checks, in this order, for lost ownership, a
// ready sample, a conversion error and the timeout. A ready sample is turned into
// (sample - zero_offset) * 1636 / 573 / 10 mA, or 0 at or below the offset; the
// scaling is a single multiplication by a fixed reciprocal. The block takes one input
// transfer in every clock cycle; each item waits in the input register, and the single
// state update between the input register and the result register loads its result.
// That update sets the rate, and it stalls only while the result register is full and
// not being taken. Configuration writes are accepted in every cycle and are meant to
// happen only while no item is in flight. Only the low AdcBits bits of the sample are
// used.

module adc_sample_sequencer_timeout import adcseq_pkg::*; #(
  parameter int unsigned AdcBits = ADC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Input channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             mode_i,
  input  logic [SAMPLE_IN_W-1:0] sample_in_i,
  input  logic                   busy_elsewhere_i,
  input  logic                   owner_lost_i,
  input  logic                   start_ok_i,
  // Result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   claim_adc_o,
  output logic                   start_conversion_o,
  output logic                   stop_conversion_o,
  output logic                   release_adc_o,
  output logic                   current_valid_o,
  output logic [CUR_W-1:0]       current_ma_o,
  output logic                   waiting_o
);

  cfg_t    cfg;
  item_t   item;
  result_t result;

  adcseq_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Gather the input fields into one item.
  assign item.mode           = mode_i;
  assign item.sample_in      = sample_in_i;
  assign item.busy_elsewhere = busy_elsewhere_i;
  assign item.owner_lost     = owner_lost_i;
  assign item.start_ok       = start_ok_i;

  adcseq_ctrl #(
    .AdcBits (AdcBits)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .item_i      (item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  // Spread the registered result over the output fields.
  assign claim_adc_o        = result.claim_adc;
  assign start_conversion_o = result.start_conversion;
  assign stop_conversion_o  = result.stop_conversion;
  assign release_adc_o      = result.release_adc;
  assign current_valid_o    = result.current_valid;
  assign current_ma_o       = result.current_ma;
  assign waiting_o          = result.waiting;

endmodule

// ----- tb/adc_sample_sequencer_timeout_tb.sv -----
// Self-checking testbench for the periodic converter sampler with timeout.
`timescale 1ns / 1ps

// The testbench drives ticks and converter events into the sequencer and checks every
// result transfer against a cycle-free model of the sequencer kept in this module. The
// model is advanced once for each accepted input transfer, and the result it gives is
// queued until the block hands back the matching result transfer.
//
// Both channel sides insert random idle cycles before each transfer. Some stretches
// run with no idle cycles at all, and one test makes the receiver hold off for a long
// spell so that the block fills up and stalls its input. Configuration writes are only
// made once every queued result has arrived and the pipeline has drained.
module adc_sample_sequencer_timeout_tb;
  import adcseq_pkg::*;

  // Codes that the package does not name: the unused item kind and the unused
  // register index. Both must be accepted and must change nothing.
  localparam logic [1:0]           MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  // Generous bound on the run, well above the slowest correct run.
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [1:0]             mode_i;
  logic [SAMPLE_IN_W-1:0] sample_in_i;
  logic                   busy_elsewhere_i;
  logic                   owner_lost_i;
  logic                   start_ok_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   claim_adc_o;
  logic                   start_conversion_o;
  logic                   stop_conversion_o;
  logic                   release_adc_o;
  logic                   current_valid_o;
  logic [CUR_W-1:0]       current_ma_o;
  logic                   waiting_o;

  adc_sample_sequencer_timeout DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .sample_in_i        (sample_in_i),
    .busy_elsewhere_i   (busy_elsewhere_i),
    .owner_lost_i       (owner_lost_i),
    .start_ok_i         (start_ok_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .claim_adc_o        (claim_adc_o),
    .start_conversion_o (start_conversion_o),
    .stop_conversion_o  (stop_conversion_o),
    .release_adc_o      (release_adc_o),
    .current_valid_o    (current_valid_o),
    .current_ma_o       (current_ma_o),
    .waiting_o          (waiting_o)
  );

  // Register copies as the block should hold them.
  logic [PERIOD_W-1:0]    cfg_period;
  logic [TIMEOUT_W-1:0]   cfg_timeout;
  logic [OFFSET_W-1:0]    cfg_offset;

  // Sequencer state as the block should hold it.
  logic                   seq_waiting;
  logic [PERIOD_W-1:0]    seq_ticks;
  logic [TIMEOUT_W-1:0]   seq_wait_ticks;
  logic                   seq_ready;
  logic                   seq_error;
  logic [SAMPLE_IN_W-1:0] seq_sample;
  logic [CUR_W-1:0]       seq_current;

  // Results predicted for accepted items, oldest first.
  result_t                sequencer_reports[$];

  int unsigned            errors;
  int unsigned            cycle_count;
  int unsigned            items_sent;
  // When set, neither side inserts idle cycles.
  bit                     steady;
  // A request to the receiver to hold off for this many cycles.
  int unsigned            hold_cycles;

  always #10 clk_i = ~clk_i;

  // Advances the sequencer model by one item and returns the result that it causes.
  function automatic result_t advance_sequencer(input item_t it);
    result_t     r;
    int unsigned tenths;
    r = '0;
    case (it.mode)
      MODE_DONE: begin
        seq_sample = it.sample_in;
        seq_ready  = 1'b1;
      end
      MODE_ERROR: begin
        seq_error = 1'b1;
      end
      MODE_TICK: begin
        if (!seq_waiting) begin
          // Idle: count up to the period, then try to claim and start the converter.
          // A busy converter or a failed start only restarts the count.
          if (seq_ticks < cfg_period) begin
            seq_ticks = seq_ticks + PERIOD_W'(1);
          end else begin
            seq_ticks = '0;
            if (!it.busy_elsewhere && it.start_ok) begin
              seq_ready          = 1'b0;
              seq_error          = 1'b0;
              seq_wait_ticks     = '0;
              r.claim_adc        = 1'b1;
              r.start_conversion = 1'b1;
              seq_waiting        = 1'b1;
            end
          end
        end else if (it.owner_lost) begin
          // Someone else took the converter: drop back quietly, no stop or release.
          seq_ready   = 1'b0;
          seq_error   = 1'b0;
          seq_waiting = 1'b0;
        end else if (seq_ready) begin
          seq_ready = 1'b0;
          if (seq_sample <= cfg_offset) begin
            seq_current = '0;
          end else begin
            tenths = ((int'(seq_sample) - int'(cfg_offset)) * MA_SCALE_X10) / ADC_REF;
            seq_current = ((tenths / TENTHS) > 2047) ? '1 : CUR_W'(tenths / TENTHS);
          end
          r.stop_conversion = 1'b1;
          r.release_adc     = 1'b1;
          r.current_valid   = 1'b1;
          seq_waiting       = 1'b0;
        end else if (seq_error) begin
          seq_error         = 1'b0;
          r.stop_conversion = 1'b1;
          r.release_adc     = 1'b1;
          seq_waiting       = 1'b0;
        end else begin
          // Nothing arrived yet: count the wait, saturating, and give up at the limit.
          if (seq_wait_ticks != WAIT_MAX) begin
            seq_wait_ticks = seq_wait_ticks + TIMEOUT_W'(1);
          end
          if (seq_wait_ticks >= cfg_timeout) begin
            r.stop_conversion = 1'b1;
            r.release_adc     = 1'b1;
            seq_waiting       = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.current_ma = seq_current;
    r.waiting    = seq_waiting;
    return r;
  endfunction

  // Every accepted input transfer advances the model and queues the result it causes.
  always @(posedge clk_i) begin
    item_t it;
    if (rst_ni && in_valid_i && in_ready_o) begin
      it.mode           = mode_i;
      it.sample_in      = sample_in_i;
      it.busy_elsewhere = busy_elsewhere_i;
      it.owner_lost     = owner_lost_i;
      it.start_ok       = start_ok_i;
      sequencer_reports.push_back(advance_sequencer(it));
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Every result transfer is compared with the oldest predicted result.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sequencer_reports.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual current %0d",
                 $time, current_ma_o);
        errors++;
      end else begin
        want = sequencer_reports.pop_front();
        check_field("claim_adc", want.claim_adc, claim_adc_o);
        check_field("start_conversion", want.start_conversion, start_conversion_o);
        check_field("stop_conversion", want.stop_conversion, stop_conversion_o);
        check_field("release_adc", want.release_adc, release_adc_o);
        check_field("current_valid", want.current_valid, current_valid_o);
        check_field("current_ma", want.current_ma, current_ma_o);
        check_field("waiting", want.waiting, waiting_o);
      end
    end
  end

  // Watchdog: a run that hangs ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: waits a random number of cycles before taking each result, or holds off
  // for a long spell when a test asks for it. The hold is counted here, in its own
  // process, so the sender carries on offering items meanwhile.
  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_ready_i = 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end else begin
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
          out_ready_i = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i) && hold_cycles == 0);
    end
  end

  // Offers one item after a random gap and returns once its transfer has taken place.
  // Valid stays high between items sent back to back.
  task automatic send_item(input logic [1:0] mode, input logic [SAMPLE_IN_W-1:0] sample,
                           input logic busy, input logic lost, input logic ok);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i           = mode;
    sample_in_i      = sample;
    busy_elsewhere_i = busy;
    owner_lost_i     = lost;
    start_ok_i       = ok;
    in_valid_i       = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (mode != MODE_UNUSED) begin
      items_sent++;
    end
  endtask

  // A clean tick: converter free, start succeeds, ownership kept.
  task automatic send_tick();
    send_item(MODE_TICK, SAMPLE_IN_W'($urandom), 1'b0, 1'b0, 1'b1);
  endtask

  // An item with every field random, the unused kind included.
  task automatic send_noise();
    send_item(2'($urandom_range(0, 3)), SAMPLE_IN_W'($urandom), 1'($urandom),
              1'($urandom), 1'($urandom));
  endtask

  // Stops offering items, then waits until every result is back and the pipeline
  // has had time to drain.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sequencer_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes one register and mirrors it in the model once the transfer has happened.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SAMPLE_PERIOD: cfg_period  = data;
      CFG_TIMEOUT:       cfg_timeout = data[TIMEOUT_W-1:0];
      CFG_ZERO_OFFSET:   cfg_offset  = data[OFFSET_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // One well-formed measurement cycle with random content: enough clean ticks to
  // start a conversion, then a sample, an error, lost ownership, a timeout or noise.
  task automatic run_episode();
    int unsigned pick;
    logic [SAMPLE_IN_W-1:0] sample;
    repeat (int'(cfg_period) + 1) send_tick();
    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      sample = ($urandom_range(0, 1) == 0) ? SAMPLE_IN_W'($urandom)
                                           : SAMPLE_IN_W'(cfg_offset + $urandom_range(0, 3));
      send_item(MODE_DONE, sample, 1'($urandom), 1'($urandom), 1'($urandom));
      if (pick == 3) begin
        send_item(MODE_ERROR, SAMPLE_IN_W'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom));
      end
      send_tick();
    end else if (pick <= 5) begin
      send_item(MODE_ERROR, SAMPLE_IN_W'($urandom), 1'($urandom), 1'($urandom),
                1'($urandom));
      send_tick();
    end else if (pick == 6) begin
      send_item(MODE_TICK, SAMPLE_IN_W'($urandom), 1'($urandom), 1'b1, 1'($urandom));
    end else if (pick <= 8) begin
      repeat (int'(cfg_timeout) + 1) send_tick();
    end else begin
      repeat ($urandom_range(1, 4)) send_noise();
    end
  endtask

  // Straight after reset the first tick starts a conversion, and a full-scale sample
  // gives the largest current.
  task automatic test_first_tick();
    send_tick();
    send_item(MODE_DONE, '1, 1'b1, 1'b1, 1'b0);
    send_tick();
  endtask

  // With a period of zero every idle tick tries to start. A busy converter, a failed
  // start, the unused item kind, lost ownership, an error event, and a sample that
  // arrives while idle (cleared by the next start) are each taken in turn.
  task automatic test_start_refusals();
    settle();
    write_reg(CFG_SAMPLE_PERIOD, '0);
    write_reg(CFG_TIMEOUT, 16'd255);
    write_reg(CFG_ZERO_OFFSET, '0);
    send_item(MODE_TICK, '0, 1'b1, 1'b0, 1'b1);
    send_item(MODE_TICK, '1, 1'b0, 1'b0, 1'b0);
    send_item(MODE_UNUSED, '1, 1'b1, 1'b1, 1'b1);
    send_tick();
    send_item(MODE_TICK, '0, 1'b0, 1'b1, 1'b1);
    send_tick();
    send_item(MODE_ERROR, '0, 1'b0, 1'b0, 1'b0);
    send_tick();
    send_item(MODE_DONE, 12'h555, 1'b0, 1'b0, 1'b0);
    send_tick();
    send_item(MODE_TICK, 12'hAAA, 1'b1, 1'b0, 1'b0);
  endtask

  // A sample equal to the largest offset reads as zero; an offset of one leaves the
  // full-scale sample just below the top current.
  task automatic test_offset_limits();
    settle();
    write_reg(CFG_ZERO_OFFSET, 16'd4095);
    send_tick();
    send_item(MODE_DONE, '1, 1'b0, 1'b0, 1'b1);
    send_tick();
    settle();
    write_reg(CFG_ZERO_OFFSET, 16'd1);
    send_tick();
    send_item(MODE_DONE, '1, 1'b0, 1'b0, 1'b1);
    send_tick();
  endtask

  // A timeout of zero and a timeout of one both give up on the first empty waiting
  // tick. Upper data bits beyond the register are ignored, and the unused index must
  // leave every register alone.
  task automatic test_timeout_limits();
    settle();
    write_reg(CFG_TIMEOUT, 16'hAB00);
    write_reg(CFG_UNUSED, 16'($urandom));
    send_tick();
    send_tick();
    settle();
    write_reg(CFG_TIMEOUT, 16'h5501);
    send_tick();
    send_tick();
  endtask

  // Lowering the period below the running count makes the next idle tick start.
  task automatic test_period_lowered();
    settle();
    write_reg(CFG_SAMPLE_PERIOD, 16'd10);
    send_tick();
    send_tick();
    settle();
    write_reg(CFG_SAMPLE_PERIOD, 16'd1);
    send_tick();
  endtask

  // The receiver holds off for a long spell while items keep coming back to back, so
  // the block fills up and must stall its input without losing anything.
  task automatic test_backpressure();
    settle();
    write_reg(CFG_SAMPLE_PERIOD, 16'd2);
    write_reg(CFG_TIMEOUT, 16'd4);
    steady      = 1'b1;
    hold_cycles = 150;
    repeat (24) send_noise();
    steady = 1'b0;
  endtask

  // Random traffic over several register settings, extremes included: mostly
  // measurement cycles with random content, the rest noise and broken sequences.
  task automatic test_random_traffic();
    int unsigned goal;
    logic [CFG_DATA_W-1:0] period, timeout, offset;
    goal = items_sent;
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: begin
          period  = '0;
          timeout = 16'd1;
          offset  = '0;
        end
        1: begin
          period  = 16'($urandom_range(1, 6));
          timeout = 16'($urandom_range(1, 16));
          offset  = 16'($urandom_range(0, 4095));
        end
        2: begin
          period  = 16'($urandom_range(0, 3));
          timeout = 16'd255;
          offset  = 16'($urandom_range(0, 300));
        end
        3: begin
          // The longest period: the idle count can only creep up, so noise only.
          period  = 16'hFFFF;
          timeout = 16'($urandom_range(1, 255));
          offset  = 16'd4095;
        end
        default: begin
          period  = 16'($urandom_range(0, 5));
          timeout = 16'($urandom_range(1, 12));
          offset  = 16'($urandom_range(0, 4095));
        end
      endcase
      write_reg(CFG_SAMPLE_PERIOD, period);
      write_reg(CFG_TIMEOUT, timeout);
      write_reg(CFG_ZERO_OFFSET, offset);
      steady = (ph == 5);
      goal += (ph == 3) ? 30 : 60;
      while (items_sent < goal) begin
        if (ph == 3 || $urandom_range(0, 4) == 0) begin
          send_noise();
        end else begin
          run_episode();
        end
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    mode_i           = MODE_TICK;
    sample_in_i      = '0;
    busy_elsewhere_i = 1'b0;
    owner_lost_i     = 1'b0;
    start_ok_i       = 1'b0;
    errors           = 0;
    cycle_count      = 0;
    items_sent       = 0;
    steady           = 1'b0;
    hold_cycles      = 0;
    cfg_period       = PERIOD_RST;
    cfg_timeout      = TIMEOUT_RST;
    cfg_offset       = OFFSET_RST;
    seq_waiting      = 1'b0;
    seq_ticks        = PERIOD_RST;
    seq_wait_ticks   = '0;
    seq_ready        = 1'b0;
    seq_error        = 1'b0;
    seq_sample       = '0;
    seq_current      = '0;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_first_tick();
    test_start_refusals();
    test_offset_limits();
    test_timeout_limits();
    test_period_lowered();
    test_backpressure();
    test_random_traffic();

    // Every result must have come back, and nothing further may follow.
    settle();
    repeat (6) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/adcseq_pkg.sv
hw/rtl/adcseq_cfg_regs.sv
hw/rtl/adcseq_ma_conv.sv
hw/rtl/adcseq_ctrl.sv
hw/rtl/adc_sample_sequencer_timeout.sv
tb/adc_sample_sequencer_timeout_tb.sv
